### design/lscs_pkg.sv
`timescale 1ns / 1ps
package lscs_pkg;
	localparam int MAX_SAMPLES = 1024;
	localparam int TRIG_BITS = 16;
	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CORDIC_STEPS = 16;
	localparam int CW = TRIG_BITS + 3;
	localparam int TW = TRIG_BITS + 2;
	localparam int ZW = 20;
	localparam int PW = 17 + TW;
	localparam int PT_W = 18;
	localparam int DW = PT_W + 1;
	localparam int SQW = 2 * DW;
	localparam int ROOT_W = SQW / 2;
	localparam int CNT_W = 5;
	localparam int CORDIC_GAIN = 652032874 >> (30 - TRIG_BITS);
	localparam int TRIG_ONE = 1 << TRIG_BITS;

	localparam logic [2:0] CFG_ANGLE_START = 3'd0;
	localparam logic [2:0] CFG_ANGLE_STEP = 3'd1;
	localparam logic [2:0] CFG_BREAK_DIST = 3'd2;
	localparam logic [2:0] CFG_NEAR_LIMIT = 3'd3;
	localparam logic [2:0] CFG_MIN_POINTS = 3'd4;

	localparam logic [0:0] KIND_OBSTACLE = 1'b0;
	localparam logic [0:0] KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic load_in;
		logic cordic_step;
		logic mul_x;
		logic mul_y;
		logic scale_y;
		logic sq_x;
		logic sq_y;
		logic close_take;
		logic eq_x;
		logic eq_y;
		logic sqrt_init;
		logic sqrt_step;
		logic load_rec;
		logic new_cluster;
		logic upd_point;
		logic adv_nonfin;
		logic end_clear;
		logic load_sum;
	} cmd_t;

	typedef struct packed {
		logic fin;
		logic scan_end;
		logic brk;
		logic close_ok;
		logic ends_ok;
		logic cordic_last;
		logic sqrt_last;
		logic out_free;
		logic emitted;
	} sts_t;

	function automatic logic [ZW-1:0] atan_q20(input logic [3:0] i);
		logic [ZW-1:0] v;
		case (i)
			4'd0: v = 20'd131072;
			4'd1: v = 20'd77376;
			4'd2: v = 20'd40884;
			4'd3: v = 20'd20753;
			4'd4: v = 20'd10417;
			4'd5: v = 20'd5213;
			4'd6: v = 20'd2607;
			4'd7: v = 20'd1304;
			4'd8: v = 20'd652;
			4'd9: v = 20'd326;
			4'd10: v = 20'd163;
			4'd11: v = 20'd81;
			4'd12: v = 20'd41;
			4'd13: v = 20'd20;
			4'd14: v = 20'd10;
			4'd15: v = 20'd5;
			default: v = 20'd0;
		endcase
		return v;
	endfunction
endpackage

### design/lscs_ifs.sv
`timescale 1ns / 1ps
interface lscs_in_if;
	logic valid;
	logic ready;
	logic [15:0] range_mm;
	logic finite;
	logic scan_end;
	modport source (output valid, range_mm, finite, scan_end, input ready);
	modport sink (input valid, range_mm, finite, scan_end, output ready);
endinterface

interface lscs_out_if;
	logic valid;
	logic ready;
	logic record_kind;
	logic [16:0] chord_mm;
	logic [14:0] subtended_angle;
	logic [10:0] cluster_points;
	logic ends_valid;
	logic [9:0] obstacles_total;
	logic last;
	modport source (output valid, record_kind, chord_mm, subtended_angle, cluster_points,
		ends_valid, obstacles_total, last, input ready);
	modport sink (input valid, record_kind, chord_mm, subtended_angle, cluster_points,
		ends_valid, obstacles_total, last, output ready);
endinterface

interface lscs_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/lscs_ctrl.sv
`timescale 1ns / 1ps
module lscs_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lscs_pkg::sts_t sts,
	output lscs_pkg::cmd_t cmd
);
	import lscs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CORD = 4'd1;
	localparam logic [3:0] S_MULX = 4'd2;
	localparam logic [3:0] S_MULY = 4'd3;
	localparam logic [3:0] S_SCALE = 4'd4;
	localparam logic [3:0] S_SQY = 4'd5;
	localparam logic [3:0] S_CMP = 4'd6;
	localparam logic [3:0] S_CLOSE = 4'd7;
	localparam logic [3:0] S_EQY = 4'd8;
	localparam logic [3:0] S_SQRT = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;
	localparam logic [3:0] S_AFTER = 4'd11;
	localparam logic [3:0] S_NEW = 4'd12;
	localparam logic [3:0] S_UPD = 4'd13;
	localparam logic [3:0] S_END = 4'd14;
	localparam logic [3:0] S_SUM = 4'd15;

	logic [3:0] state_q, state_d;
	logic end_phase_q, end_phase_d;
	logic new_done_q, new_done_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		end_phase_d = end_phase_q;
		new_done_d = new_done_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					end_phase_d = 1'b0;
					new_done_d = 1'b0;
					state_d = S_CORD;
				end
			end
			S_CORD: begin
				if (!sts.fin) begin
					state_d = S_CLOSE;
				end else begin
					cmd.cordic_step = 1'b1;
					if (sts.cordic_last) state_d = S_MULX;
				end
			end
			S_MULX: begin
				cmd.mul_x = 1'b1;
				state_d = S_MULY;
			end
			S_MULY: begin
				cmd.mul_y = 1'b1;
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale_y = 1'b1;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.sq_x = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.sq_y = 1'b1;
				state_d = S_UPD;
			end
			S_CLOSE: begin
				cmd.close_take = 1'b1;
				cmd.eq_x = 1'b1;
				if (sts.close_ok && sts.ends_ok) state_d = S_EQY;
				else if (sts.close_ok) state_d = S_EMIT;
				else state_d = S_AFTER;
			end
			S_EQY: begin
				cmd.eq_y = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_init = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.sqrt_last || !sts.ends_ok) begin
					if (sts.out_free) begin
						cmd.load_rec = 1'b1;
						state_d = S_AFTER;
					end
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			S_AFTER: begin
				if (end_phase_q) state_d = S_SUM;
				else if (sts.fin) state_d = S_NEW;
				else begin
					cmd.adv_nonfin = 1'b1;
					state_d = S_END;
				end
			end
			S_NEW: begin
				cmd.new_cluster = 1'b1;
				new_done_d = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				if (sts.brk && !new_done_q) begin
					state_d = S_CLOSE;
				end else begin
					cmd.upd_point = 1'b1;
					state_d = S_END;
				end
			end
			S_END: begin
				if (!sts.scan_end) state_d = S_IDLE;
				else if (!sts.emitted) begin
					end_phase_d = 1'b1;
					state_d = S_CLOSE;
				end else begin
					cmd.end_clear = 1'b1;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (sts.out_free) begin
					cmd.load_sum = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			end_phase_q <= 1'b0;
			new_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			end_phase_q <= end_phase_d;
			new_done_q <= new_done_d;
		end
	end
endmodule

### design/lscs_dp.sv
`timescale 1ns / 1ps
module lscs_dp (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	lscs_in_if.sink samples,
	lscs_out_if.source records,
	lscs_cfg_if.sink cfg,
	input lscs_pkg::cmd_t cmd,
	output lscs_pkg::sts_t sts
);
	import lscs_pkg::*;

	localparam logic signed [CW-1:0] T_ONE = CW'(TRIG_ONE);
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(TRIG_ONE / 2);

	// configuration
	logic [15:0] angle_start_q;
	logic [11:0] angle_step_q;
	logic [15:0] break_q;
	logic [15:0] near_q;
	logic [10:0] min_pts_q;

	// item being worked on
	logic [15:0] range_q;
	logic fin_q, end_q;
	logic [15:0] theta_q;
	logic [15:0] theta_d;

	// cordic and products
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [PW-1:0] prod_q;
	logic signed [PT_W-1:0] x_q, y_q;
	logic [SQW-1:0] sqa_q, sqb_q;

	// square root
	logic [SQW-1:0] rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	// scan and cluster state
	logic [IDX_W-1:0] idx_q;
	logic signed [PT_W-1:0] prev_x_q, prev_y_q;
	logic prev_fin_q, open_q;
	logic [10:0] count_q;
	logic signed [PT_W-1:0] fx_q, fy_q, lx_q, ly_q;
	logic [15:0] fa_q, la_q;
	logic fv_q, lv_q;
	logic [9:0] obs_q;
	logic emitted_q;

	// output register
	logic out_valid_q;
	logic kind_q, ev_q, last_q;
	logic [16:0] chord_q;
	logic [14:0] ang_q;
	logic [10:0] pts_q;
	logic [9:0] cnt_out_q;

	logic signed [CW-1:0] qc, qs, dxs, dys;
	logic signed [TW-1:0] c_sel, s_sel;
	logic signed [DW-1:0] dpx, dpy, dex, dey;
	logic [SQW:0] d2;
	logic [31:0] b2;
	logic [14:0] dang, fold;
	logic [ROOT_W+3:0] cand, trial;
	logic [IDX_W:0] idx_inc;
	logic [3:0] step_i;

	function automatic logic signed [PT_W-1:0] scale_mm(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] r;
		r = (p + ROUND_HALF) >>> TRIG_BITS;
		if (r > PW'(65535)) return PT_W'(65535);
		if (r < -PW'(65535)) return -PT_W'(65535);
		return PT_W'(r);
	endfunction

	assign theta_d = angle_start_q + 16'(32'(idx_q) * 32'(angle_step_q));
	assign step_i = cnt_q[3:0];
	assign dxs = cy_q >>> step_i;
	assign dys = cx_q >>> step_i;

	assign qc = (cx_q > T_ONE) ? T_ONE : ((cx_q < -T_ONE) ? -T_ONE : cx_q);
	assign qs = (cy_q > T_ONE) ? T_ONE : ((cy_q < -T_ONE) ? -T_ONE : cy_q);

	always_comb begin
		case (theta_q[15:14])
			2'd0: begin
				c_sel = TW'(qc);
				s_sel = TW'(qs);
			end
			2'd1: begin
				c_sel = -TW'(qs);
				s_sel = TW'(qc);
			end
			2'd2: begin
				c_sel = -TW'(qc);
				s_sel = -TW'(qs);
			end
			default: begin
				c_sel = TW'(qs);
				s_sel = -TW'(qc);
			end
		endcase
	end

	assign dpx = DW'(x_q) - DW'(prev_x_q);
	assign dpy = DW'(y_q) - DW'(prev_y_q);
	assign dex = DW'(fx_q) - DW'(lx_q);
	assign dey = DW'(fy_q) - DW'(ly_q);
	assign d2 = {1'b0, sqa_q} + {1'b0, sqb_q};
	assign b2 = break_q * break_q;

	assign dang = 15'(la_q - fa_q);
	assign fold = (dang > 15'd16384) ? 15'(16'd32768 - {1'b0, dang}) : dang;

	assign cand = {rem_q, rad_q[SQW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign idx_inc = {1'b0, idx_q} + 1'b1;

	assign sts.fin = fin_q;
	assign sts.scan_end = end_q;
	assign sts.brk = !prev_fin_q || !open_q || (d2 > (SQW + 1)'(b2));
	assign sts.close_ok = open_q && (count_q > min_pts_q);
	assign sts.ends_ok = fv_q && lv_q;
	assign sts.cordic_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
	assign sts.sqrt_last = (cnt_q == CNT_W'(ROOT_W));
	assign sts.out_free = !out_valid_q || records.ready;
	assign sts.emitted = emitted_q;

	assign samples.ready = in_ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= 16'h8000;
			angle_step_q <= 12'd182;
			break_q <= 16'd500;
			near_q <= 16'd600;
			min_pts_q <= 11'd7;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ANGLE_START: angle_start_q <= cfg.data;
				CFG_ANGLE_STEP: angle_step_q <= cfg.data[11:0];
				CFG_BREAK_DIST: break_q <= cfg.data;
				CFG_NEAR_LIMIT: near_q <= cfg.data;
				CFG_MIN_POINTS: min_pts_q <= cfg.data[10:0];
				default: ;
			endcase
		end
	end

	// datapath work registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			range_q <= samples.range_mm;
			fin_q <= samples.finite;
			end_q <= samples.scan_end;
			theta_q <= theta_d;
			cx_q <= CW'(CORDIC_GAIN);
			cy_q <= '0;
			cz_q <= ZW'({theta_d[13:0], 4'b0000});
		end
		if (cmd.cordic_step) begin
			if (!cz_q[ZW-1]) begin
				cx_q <= cx_q - dxs;
				cy_q <= cy_q + dys;
				cz_q <= cz_q - $signed(atan_q20(step_i));
			end else begin
				cx_q <= cx_q + dxs;
				cy_q <= cy_q - dys;
				cz_q <= cz_q + $signed(atan_q20(step_i));
			end
		end
		if (cmd.mul_x) prod_q <= PW'($signed({1'b0, range_q}) * c_sel);
		if (cmd.mul_y) begin
			x_q <= scale_mm(prod_q);
			prod_q <= PW'($signed({1'b0, range_q}) * s_sel);
		end
		if (cmd.scale_y) y_q <= scale_mm(prod_q);
		if (cmd.sq_x) sqa_q <= SQW'(dpx * dpx);
		if (cmd.sq_y) sqb_q <= SQW'(dpy * dpy);
		if (cmd.eq_x) sqa_q <= SQW'(dex * dex);
		if (cmd.eq_y) sqb_q <= SQW'(dey * dey);
		if (cmd.sqrt_init) begin
			rad_q <= d2[SQW-1:0];
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			rad_q <= {rad_q[SQW-3:0], 2'b00};
			if (cand >= trial) begin
				rem_q <= (ROOT_W + 2)'(cand - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= (ROOT_W + 2)'(cand);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_in || cmd.sqrt_init) begin
			cnt_q <= '0;
		end else if (cmd.cordic_step || cmd.sqrt_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// scan and cluster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_fin_q <= 1'b0;
			open_q <= 1'b0;
			count_q <= '0;
			fx_q <= '0;
			fy_q <= '0;
			lx_q <= '0;
			ly_q <= '0;
			fa_q <= '0;
			la_q <= '0;
			fv_q <= 1'b0;
			lv_q <= 1'b0;
			obs_q <= '0;
			emitted_q <= 1'b0;
		end else begin
			if (cmd.load_in) emitted_q <= 1'b0;
			if (cmd.close_take) begin
				open_q <= 1'b0;
				if (sts.close_ok && obs_q != 10'd1023) obs_q <= obs_q + 1'b1;
			end
			if (cmd.load_rec) emitted_q <= 1'b1;
			if (cmd.new_cluster) begin
				open_q <= 1'b1;
				count_q <= '0;
				fv_q <= 1'b0;
				lv_q <= 1'b0;
			end
			if (cmd.upd_point) begin
				if (count_q != 11'd2047) count_q <= count_q + 1'b1;
				if (range_q > near_q) begin
					if (!fv_q) begin
						fx_q <= x_q;
						fy_q <= y_q;
						fa_q <= theta_q;
						fv_q <= 1'b1;
					end
					lx_q <= x_q;
					ly_q <= y_q;
					la_q <= theta_q;
					lv_q <= 1'b1;
				end
				prev_x_q <= x_q;
				prev_y_q <= y_q;
				prev_fin_q <= 1'b1;
			end
			if (cmd.adv_nonfin) prev_fin_q <= 1'b0;
			if (cmd.upd_point || cmd.adv_nonfin) begin
				idx_q <= (idx_inc >= (IDX_W + 1)'(MAX_SAMPLES)) ? '0 : idx_inc[IDX_W-1:0];
			end
			if (cmd.end_clear) open_q <= 1'b0;
			if (cmd.load_sum) begin
				idx_q <= '0;
				prev_fin_q <= 1'b0;
				open_q <= 1'b0;
				count_q <= '0;
				fv_q <= 1'b0;
				lv_q <= 1'b0;
				obs_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_rec || cmd.load_sum) begin
			out_valid_q <= 1'b1;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rec) begin
			kind_q <= KIND_OBSTACLE;
			chord_q <= sts.ends_ok ? root_q[16:0] : 17'd0;
			ang_q <= sts.ends_ok ? fold : 15'd0;
			pts_q <= count_q;
			ev_q <= sts.ends_ok;
			cnt_out_q <= obs_q;
			last_q <= 1'b0;
		end
		if (cmd.load_sum) begin
			kind_q <= KIND_SUMMARY;
			chord_q <= '0;
			ang_q <= '0;
			pts_q <= '0;
			ev_q <= 1'b0;
			cnt_out_q <= obs_q;
			last_q <= 1'b1;
		end
	end

	assign records.valid = out_valid_q;
	assign records.record_kind = kind_q;
	assign records.chord_mm = chord_q;
	assign records.subtended_angle = ang_q;
	assign records.cluster_points = pts_q;
	assign records.ends_valid = ev_q;
	assign records.obstacles_total = cnt_out_q;
	assign records.last = last_q;
endmodule

### design/lidar_scan_cluster_segmenter_unit.sv
// flow: a finite sample runs the 16-step cordic, the multiply, scale and square states
// and the point update before the next accept, with a closing pass when it opens a new
// cluster; a non-finite one runs only the closing pass; an obstacle record adds the
// bit-serial root, none without endpoints; a scan end adds the summary, after a closing pass if one runs
// throughput: one item at a time, the next is taken once the last is done; a record
// waits only while the output register still holds an unaccepted one
`timescale 1ns / 1ps
module lidar_scan_cluster_segmenter_unit (
	input logic clk,
	input logic arst_n,
	lscs_in_if.sink samples,
	lscs_out_if.source records,
	lscs_cfg_if.sink cfg
);
	import lscs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	lscs_ctrl u_ctrl (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (samples.valid),
		.in_ready (in_ready),
		.sts (sts),
		.cmd (cmd)
	);

	lscs_dp u_dp (
		.clk (clk),
		.arst_n (arst_n),
		.in_ready (in_ready),
		.samples (samples),
		.records (records),
		.cfg (cfg),
		.cmd (cmd),
		.sts (sts)
	);
endmodule

### tb/sv/tb_lidar_scan_cluster_segmenter_unit.sv
`timescale 1ns / 1ps
class segment_scoreboard;
	typedef struct packed {
		logic kind;
		logic [16:0] chord;
		logic [14:0] ang;
		logic [10:0] pts;
		logic ev;
		logic [9:0] cnt;
		logic last;
	} rec_t;

	typedef struct {
		longint x;
		longint y;
		int unsigned ang;
		bit ok;
	} end_pt_t;

	rec_t pending[$];
	int mismatches;

	int ang_start;
	int unsigned ang_step, brk_dist, near_lim, min_pts;
	int unsigned idx, n_pts, n_obs;
	longint px, py;
	bit prev_fin, open;
	end_pt_t first_pt, last_pt;

	function void clear();
		ang_start = -32768;
		ang_step = 182;
		brk_dist = 500;
		near_lim = 600;
		min_pts = 7;
		idx = 0;
		n_pts = 0;
		n_obs = 0;
		px = 0;
		py = 0;
		prev_fin = 0;
		open = 0;
		first_pt = '{0, 0, 0, 0};
		last_pt = '{0, 0, 0, 0};
		mismatches = 0;
		pending.delete();
	endfunction

	function void set_reg(logic [2:0] i, logic [15:0] v);
		case (i)
			lscs_pkg::CFG_ANGLE_START: ang_start = $signed(v);
			lscs_pkg::CFG_ANGLE_STEP: ang_step = v[11:0];
			lscs_pkg::CFG_BREAK_DIST: brk_dist = v;
			lscs_pkg::CFG_NEAR_LIMIT: near_lim = v;
			lscs_pkg::CFG_MIN_POINTS: min_pts = v[10:0];
			default: ;
		endcase
	endfunction

	static function longint shr(longint v, int s);
		return v >>> s;
	endfunction

	static function longint lim(longint v, longint l);
		if (v > l)
			return l;
		if (v < -l)
			return -l;
		return v;
	endfunction

	static function void sincos(int unsigned th, output longint c, output longint s);
		longint x, y, z, dx, dy, qc, qs;
		longint atn[16];
		atn = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
			652, 326, 163, 81, 41, 20, 10, 5};
		x = 652032874 >>> 14;
		y = 0;
		z = longint'(th & 16'h3fff) * 16;
		for (int i = 0; i < 16; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atn[i];
			end else begin
				x += dx; y -= dy; z += atn[i];
			end
		end
		qc = lim(x, 65536);
		qs = lim(y, 65536);
		case ((th >> 14) & 3)
			0: begin c = qc; s = qs; end
			1: begin c = -qs; s = qc; end
			2: begin c = -qc; s = -qs; end
			default: begin c = qs; s = -qc; end
		endcase
	endfunction

	static function longint to_mm(int unsigned r, longint t);
		return lim(shr(longint'(r) * t + 32768, 16), 65535);
	endfunction

	static function longint root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function int close_cluster();
		rec_t r;
		longint dx, dy;
		int unsigned d;
		bit was;
		was = open;
		open = 0;
		if (!was || n_pts <= min_pts)
			return 0;
		if (n_obs < 1023)
			n_obs++;
		r = '0;
		r.kind = lscs_pkg::KIND_OBSTACLE;
		if (first_pt.ok && last_pt.ok) begin
			dx = first_pt.x - last_pt.x;
			dy = first_pt.y - last_pt.y;
			d = (last_pt.ang - first_pt.ang) & 32'h7fff;
			r.chord = root(dx * dx + dy * dy);
			r.ang = d > 16384 ? 32768 - d : d;
			r.ev = 1;
		end
		r.pts = n_pts;
		r.cnt = n_obs;
		pending.insert(pending.size(), r);
		return 1;
	endfunction

	function void note_sample(logic [15:0] rng, logic fin, logic send);
		int n;
		int unsigned th;
		longint c, s, x, y, dx, dy;
		bit brk;
		rec_t r;
		n = 0;
		if (fin) begin
			th = (ang_start + idx * ang_step) & 32'hffff;
			sincos(th, c, s);
			x = to_mm(rng, c);
			y = to_mm(rng, s);
			brk = !prev_fin || !open;
			if (!brk) begin
				dx = x - px;
				dy = y - py;
				brk = (dx * dx + dy * dy) > longint'(brk_dist) * brk_dist;
			end
			if (brk) begin
				n += close_cluster();
				open = 1;
				n_pts = 0;
				first_pt.ok = 0;
				last_pt.ok = 0;
			end
			if (n_pts < 2047)
				n_pts++;
			if (rng > near_lim) begin
				if (!first_pt.ok)
					first_pt = '{x, y, th, 1};
				last_pt = '{x, y, th, 1};
			end
			px = x;
			py = y;
			prev_fin = 1;
		end else begin
			n += close_cluster();
			prev_fin = 0;
		end
		idx = (idx + 1 >= 1024) ? 0 : idx + 1;
		if (send) begin
			if (n == 0)
				void'(close_cluster());
			r = '0;
			r.kind = lscs_pkg::KIND_SUMMARY;
			r.cnt = n_obs;
			r.last = 1;
			pending.insert(pending.size(), r);
			idx = 0;
			prev_fin = 0;
			open = 0;
			n_pts = 0;
			first_pt.ok = 0;
			last_pt.ok = 0;
			n_obs = 0;
		end
	endfunction

	function void check_record(rec_t got);
		rec_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected record %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("record mismatch: expected kind %0d chord %0d ang %0d pts %0d",
					want.kind, want.chord, want.ang, want.pts,
					" ev %0d cnt %0d last %0d", want.ev, want.cnt, want.last);
				$display("  got kind %0d chord %0d ang %0d pts %0d",
					got.kind, got.chord, got.ang, got.pts,
					" ev %0d cnt %0d last %0d", got.ev, got.cnt, got.last);
			end
		end
	endfunction
endclass

module tb_lidar_scan_cluster_segmenter_unit;
	import lscs_pkg::*;

	localparam logic [2:0] CFG_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	int burst_left;
	int cyc = 0;
	segment_scoreboard sb;

	lscs_in_if samples();
	lscs_out_if records();
	lscs_cfg_if cfg();

	lidar_scan_cluster_segmenter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples.sink),
		.records(records.source),
		.cfg(cfg.sink)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("tb_lidar_scan_cluster_segmenter_unit: FAIL");
		$finish;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && records.valid && records.ready)
			sb.check_record({records.record_kind, records.chord_mm, records.subtended_angle,
				records.cluster_points, records.ends_valid, records.obstacles_total,
				records.last});
		case ((cyc >> 8) % 3)
			0: records.ready <= 1'b1;
			1: records.ready <= ($urandom_range(0, 3) != 0);
			default: records.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic write_reg(logic [2:0] i, logic [15:0] v);
		cfg.valid <= 1'b1;
		cfg.index <= i;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(i, v);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [15:0] rng, logic fin, logic send);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
			if (gap > 0) begin
				samples.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		samples.valid <= 1'b1;
		samples.range_mm <= rng;
		samples.finite <= fin;
		samples.scan_end <= send;
		do @(posedge clk); while (!samples.ready);
		sb.note_sample(rng, fin, send);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_scan(int len);
		int unsigned base;
		int mode;
		base = $urandom_range(700, 5000);
		for (int i = 0; i < len; i++) begin
			mode = $urandom_range(0, 19);
			if (mode == 0)
				send_sample(16'($urandom), 1'b0, i == len - 1);
			else if (mode == 1)
				send_sample(16'($urandom), 1'b1, i == len - 1);
			else if (mode == 2)
				base = $urandom_range(0, 65535);
			else begin
				base = base + $urandom_range(0, 120) - 60;
				if (base > 65535)
					base = $urandom_range(700, 3000);
				send_sample(base[15:0], 1'b1, i == len - 1);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		burst_left = 0;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.range_mm = '0;
		samples.finite = 1'b0;
		samples.scan_end = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes, non-finite close, break on scan end
		for (int i = 0; i < 9; i++)
			send_sample(16'(1000 + i), 1'b1, 1'b0);
		send_sample(16'hffff, 1'b0, 1'b0);
		for (int i = 0; i < 8; i++)
			send_sample(16'd500, 1'b1, 1'b0);
		send_sample(16'hffff, 1'b1, 1'b0);
		send_sample(16'd0, 1'b1, 1'b1);
		send_sample(16'd0, 1'b0, 1'b1);
		drain();

		write_reg(CFG_ANGLE_START, 16'h7fff);
		write_reg(CFG_ANGLE_STEP, 16'd4095);
		write_reg(CFG_BREAK_DIST, 16'hffff);
		write_reg(CFG_NEAR_LIMIT, 16'd0);
		write_reg(CFG_MIN_POINTS, 16'd0);
		write_reg(CFG_UNUSED, 16'h1234);
		send_sample(16'hffff, 1'b1, 1'b0);
		send_sample(16'h0001, 1'b1, 1'b0);
		send_sample(16'h8000, 1'b1, 1'b1);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_ANGLE_START, 16'h8000);
					write_reg(CFG_ANGLE_STEP, 16'd182);
					write_reg(CFG_BREAK_DIST, 16'd500);
					write_reg(CFG_NEAR_LIMIT, 16'd600);
					write_reg(CFG_MIN_POINTS, 16'd7);
				end
				1: begin
					write_reg(CFG_BREAK_DIST, 16'd0);
					write_reg(CFG_MIN_POINTS, 16'd1024);
				end
				default: begin
					write_reg(CFG_ANGLE_START, 16'($urandom));
					write_reg(CFG_ANGLE_STEP, 16'($urandom_range(0, 4095)));
					write_reg(CFG_BREAK_DIST, 16'($urandom_range(0, 400)));
					write_reg(CFG_NEAR_LIMIT, 16'($urandom_range(0, 3000)));
					write_reg(CFG_MIN_POINTS, 16'($urandom_range(0, 6)));
				end
			endcase
			for (int k = 0; k < 4; k++)
				random_scan($urandom_range(5, 35));
			drain();
		end

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_lidar_scan_cluster_segmenter_unit: PASS");
		else
			$display("tb_lidar_scan_cluster_segmenter_unit: FAIL");
		$finish;
	end
endmodule

### sim.f
design/lscs_pkg.sv
design/lscs_ifs.sv
design/lscs_ctrl.sv
design/lscs_dp.sv
design/lidar_scan_cluster_segmenter_unit.sv
tb/sv/tb_lidar_scan_cluster_segmenter_unit.sv
